### rtl/lfb_pkg.sv
// Package for the lagged Fibonacci byte generator: shared types, constants,
// the lag pair tables and the seeding phase encoding.
// Depends on nothing; all other files but lfb_ram refer to it by scope.
package lfb_pkg;

  // Field widths.
  localparam int unsigned CNT_W  = 7;   // byte_count field
  localparam int unsigned BYTE_W = 8;   // random_byte field
  localparam int unsigned WORD_W = 32;  // ring word
  localparam int unsigned DEG_W  = 11;  // degree and separation values
  localparam int unsigned WARM_W = 14;  // discard counter
  localparam int unsigned LAG_W  = 4;   // lag_type register

  // Bit position of the emitted byte inside a ring sum.
  localparam int unsigned BYTE_LSB = 23;

  // Seeding chain constants.
  localparam logic [WORD_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [WORD_W-1:0] LCG_INC = 32'd12345;

  // Register reset values.
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;
  localparam logic [LAG_W-1:0]  LAG_RESET  = 4'd0;

  // Register index taken from the word address.
  typedef enum logic {
    REG_SEED = 1'b0,
    REG_LAG  = 1'b1
  } reg_idx_e;

  // Burst queue between front and back.
  localparam int unsigned FQ_DEPTH = 2;
  localparam int unsigned FQ_PTR_W = 1;
  localparam int unsigned FQ_CNT_W = 2;

  // Result queue at the output.
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = 2;
  localparam int unsigned OQ_CNT_W = 3;

  // Seeding phases of the back end.
  typedef enum logic [1:0] {
    PH_FILL  = 2'd0,
    PH_MOD   = 2'd1,
    PH_WARM  = 2'd2,
    PH_READY = 2'd3
  } phase_e;

  // Head of the burst queue as seen by the back end.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } burst_req_t;

  // One stored result.
  typedef struct packed {
    logic [BYTE_W-1:0] rbyte;
    logic              last;
  } result_t;

  // Degree of each lag pair.
  function automatic logic [DEG_W-1:0] lag_degree(input logic [LAG_W-1:0] lag);
    logic [DEG_W-1:0] d;
    unique case (lag)
      4'd0:  d = 11'd401;
      4'd1:  d = 11'd433;
      4'd2:  d = 11'd487;
      4'd3:  d = 11'd673;
      4'd4:  d = 11'd641;
      4'd5:  d = 11'd809;
      4'd6:  d = 11'd857;
      4'd7:  d = 11'd967;
      4'd8:  d = 11'd1033;
      4'd9:  d = 11'd1063;
      4'd10: d = 11'd1129;
      4'd11: d = 11'd1153;
      4'd12: d = 11'd1223;
      4'd13: d = 11'd1249;
      4'd14: d = 11'd1367;
      4'd15: d = 11'd1423;
      default: d = 11'd401;
    endcase
    return d;
  endfunction

  // Separation of each lag pair; always below its degree.
  function automatic logic [DEG_W-1:0] lag_separation(input logic [LAG_W-1:0] lag);
    logic [DEG_W-1:0] s;
    unique case (lag)
      4'd0:  s = 11'd170;
      4'd1:  s = 11'd118;
      4'd2:  s = 11'd94;
      4'd3:  s = 11'd252;
      4'd4:  s = 11'd36;
      4'd5:  s = 11'd92;
      4'd6:  s = 11'd402;
      4'd7:  s = 11'd210;
      4'd8:  s = 11'd498;
      4'd9:  s = 11'd208;
      4'd10: s = 11'd208;
      4'd11: s = 11'd268;
      4'd12: s = 11'd588;
      4'd13: s = 11'd237;
      4'd14: s = 11'd134;
      4'd15: s = 11'd228;
      default: s = 11'd170;
    endcase
    return s;
  endfunction

endpackage

### rtl/lfb_ram.sv
// Generic RAM: one write port and two read ports with registered read data.
// Depends on nothing.
module lfb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1423,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### rtl/lfb_mod.sv
// Iterative remainder unit: one restoring step per cycle, one step per dividend bit.
// Depends on lfb_pkg for the word and degree widths.
module lfb_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lfb_pkg::WORD_W-1:0] dividend_i,
  input  logic [lfb_pkg::DEG_W-1:0]  divisor_i,
  output logic                      done_o,
  output logic [lfb_pkg::DEG_W-1:0]  rem_o
);

  localparam int unsigned STEP_W = $clog2(lfb_pkg::WORD_W) + 1;

  logic                       busy_q;
  logic [STEP_W-1:0]          step_q;
  logic                       done_q;
  logic [lfb_pkg::WORD_W-1:0] div_q;
  logic [lfb_pkg::DEG_W-1:0]  dsr_q;
  logic [lfb_pkg::DEG_W-1:0]  rem_q;
  logic [lfb_pkg::DEG_W:0]    trial;
  logic [lfb_pkg::DEG_W-1:0]  rem_d;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, div_q[lfb_pkg::WORD_W-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = lfb_pkg::DEG_W'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[lfb_pkg::DEG_W-1:0];
    end
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(lfb_pkg::WORD_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      div_q <= {div_q[lfb_pkg::WORD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### rtl/lfb_front.sv
// Front end: accepts requests, drops empty ones, clamps oversized counts and
// holds them in a two-entry burst queue. Depends on lfb_pkg.
module lfb_front #(
  parameter int unsigned MAX_BURST = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [lfb_pkg::CNT_W-1:0]  byte_count_i,
  output logic                       full_o,
  output lfb_pkg::burst_req_t        req_o,
  input  logic                       req_pop_i
);

  logic [lfb_pkg::CNT_W-1:0]    q_mem [lfb_pkg::FQ_DEPTH];
  logic [lfb_pkg::FQ_PTR_W-1:0] wr_ptr_q;
  logic [lfb_pkg::FQ_PTR_W-1:0] rd_ptr_q;
  logic [lfb_pkg::FQ_CNT_W-1:0] cnt_q;
  logic [lfb_pkg::CNT_W-1:0]    clamped;
  logic                         enq;
  logic                         deq;

  // Classify the incoming item: a zero count is dropped, a large one clamped.
  assign clamped = (byte_count_i > lfb_pkg::CNT_W'(MAX_BURST)) ?
                   lfb_pkg::CNT_W'(MAX_BURST) : byte_count_i;
  assign full_o  = (cnt_q == lfb_pkg::FQ_CNT_W'(lfb_pkg::FQ_DEPTH));
  assign enq     = push_i && !full_o && (byte_count_i != '0);
  assign deq     = req_pop_i && (cnt_q != '0);

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (enq) begin
        wr_ptr_q <= wr_ptr_q + lfb_pkg::FQ_PTR_W'(1);
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + lfb_pkg::FQ_PTR_W'(1);
      end
      if (enq && !deq) begin
        cnt_q <= cnt_q + lfb_pkg::FQ_CNT_W'(1);
      end else if (deq && !enq) begin
        cnt_q <= cnt_q - lfb_pkg::FQ_CNT_W'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem[wr_ptr_q] <= clamped;
    end
  end

  assign req_o.valid = (cnt_q != '0);
  assign req_o.count = q_mem[rd_ptr_q];

endmodule

### rtl/lfb_back.sv
// Back end: seeds the ring (chain fill, remainder, discard run), then draws
// one byte per cycle for each queued burst, while the result queue has room.
// Depends on lfb_pkg, lfb_ram and lfb_mod.
module lfb_back #(
  parameter int unsigned RING_DEPTH = 1423
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        reseed_i,
  input  logic [lfb_pkg::WORD_W-1:0]  seed_i,
  input  logic [lfb_pkg::LAG_W-1:0]   lag_i,
  input  lfb_pkg::burst_req_t         req_i,
  output logic                        req_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [lfb_pkg::BYTE_W-1:0]  random_byte_o,
  output logic                        last_o
);

  localparam int unsigned IW = $clog2(RING_DEPTH);

  lfb_pkg::phase_e state_q, state_d;

  logic [IW-1:0]               deg;
  logic [IW-1:0]               sep;
  logic [IW-1:0]               fill_idx_q;
  logic [lfb_pkg::WORD_W-1:0]  chain_q;
  logic [lfb_pkg::WORD_W-1:0]  fill_word;
  logic                        fill_last;
  logic                        mod_start;
  logic                        mod_done;
  logic [lfb_pkg::DEG_W-1:0]   mod_rem;
  logic [lfb_pkg::WARM_W-1:0]  warm_cnt_q;
  logic [lfb_pkg::WARM_W-1:0]  warm_load;
  logic [IW-1:0]               front_q;
  logic [IW-1:0]               rear_q;
  logic                        busy_q;
  logic [lfb_pkg::CNT_W-1:0]   left_q;
  logic                        credit_ok;
  logic                        issue_warm;
  logic                        issue_rd;
  logic                        issue;
  logic                        load_burst;
  logic                        b_valid_q;
  logic                        b_emit_q;
  logic                        b_last_q;
  logic [IW-1:0]               b_addr_q;
  logic [lfb_pkg::WORD_W-1:0]  rd_front;
  logic [lfb_pkg::WORD_W-1:0]  rd_rear;
  logic [lfb_pkg::WORD_W-1:0]  sum;
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [lfb_pkg::WORD_W-1:0]  ram_wdata;
  lfb_pkg::result_t            oq_mem [lfb_pkg::OQ_DEPTH];
  logic [lfb_pkg::OQ_PTR_W-1:0] oq_wr_q;
  logic [lfb_pkg::OQ_PTR_W-1:0] oq_rd_q;
  logic [lfb_pkg::OQ_CNT_W-1:0] oq_cnt_q;
  logic                        oq_push;
  logic                        oq_pop;
  lfb_pkg::result_t            oq_word;

  // Step a ring index, wrapping at the active degree.
  function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                            input logic [IW-1:0] d);
    logic [IW:0] n;
    n = {1'b0, idx} + (IW+1)'(1);
    return (n >= {1'b0, d}) ? '0 : n[IW-1:0];
  endfunction

  // Lag pair of the current configuration.
  assign deg = IW'(lfb_pkg::lag_degree(lag_i));
  assign sep = IW'(lfb_pkg::lag_separation(lag_i));

  // Chain fill: the first word is the seed, then one chain step per cycle.
  assign fill_word = (fill_idx_q == '0) ? seed_i :
                     lfb_pkg::WORD_W'(chain_q * lfb_pkg::LCG_MUL) + lfb_pkg::LCG_INC;
  assign fill_last = (fill_idx_q == deg - IW'(1));
  assign mod_start = (state_q == lfb_pkg::PH_FILL) && fill_last && !reseed_i;

  // Discard run length: ten times the degree plus the final chain word mod degree.
  assign warm_load = (lfb_pkg::WARM_W'(deg) << 3) + (lfb_pkg::WARM_W'(deg) << 1) +
                     lfb_pkg::WARM_W'(mod_rem);

  lfb_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (fill_word),
    .divisor_i  (lfb_pkg::lag_degree(lag_i)),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Draw issue: discarded draws during warm-up, emitted draws for bursts.
  assign credit_ok  = (oq_cnt_q < lfb_pkg::OQ_CNT_W'(lfb_pkg::OQ_DEPTH - 1));
  assign issue_warm = (state_q == lfb_pkg::PH_WARM);
  assign issue_rd   = (state_q == lfb_pkg::PH_READY) && busy_q && credit_ok;
  assign issue      = issue_warm || issue_rd;
  assign load_burst = (state_q == lfb_pkg::PH_READY) && req_i.valid &&
                      (!busy_q || (issue_rd && (left_q == lfb_pkg::CNT_W'(1))));
  assign req_pop_o  = load_burst;

  // Seeding phase register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfb_pkg::PH_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  // Next phase; a configuration write restarts seeding from any phase.
  always_comb begin
    state_d = state_q;
    if (reseed_i) begin
      state_d = lfb_pkg::PH_FILL;
    end else begin
      unique case (state_q)
        lfb_pkg::PH_FILL: begin
          if (fill_last) state_d = lfb_pkg::PH_MOD;
        end
        lfb_pkg::PH_MOD: begin
          if (mod_done) state_d = lfb_pkg::PH_WARM;
        end
        lfb_pkg::PH_WARM: begin
          if (warm_cnt_q == lfb_pkg::WARM_W'(1)) state_d = lfb_pkg::PH_READY;
        end
        lfb_pkg::PH_READY: begin
          state_d = lfb_pkg::PH_READY;
        end
        default: state_d = lfb_pkg::PH_FILL;
      endcase
    end
  end

  // Indices, counters and the draw pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_idx_q <= '0;
      warm_cnt_q <= '0;
      front_q    <= '0;
      rear_q     <= '0;
      busy_q     <= 1'b0;
      left_q     <= '0;
      b_valid_q  <= 1'b0;
      b_emit_q   <= 1'b0;
    end else if (reseed_i) begin
      fill_idx_q <= '0;
      busy_q     <= 1'b0;
      b_valid_q  <= 1'b0;
      b_emit_q   <= 1'b0;
    end else begin
      if (state_q == lfb_pkg::PH_FILL) begin
        fill_idx_q <= fill_last ? '0 : fill_idx_q + IW'(1);
      end
      if ((state_q == lfb_pkg::PH_MOD) && mod_done) begin
        warm_cnt_q <= warm_load;
        front_q    <= sep;
        rear_q     <= '0;
      end
      if (issue) begin
        front_q <= advance(front_q, deg);
        rear_q  <= advance(rear_q, deg);
      end
      if (issue_warm) begin
        warm_cnt_q <= warm_cnt_q - lfb_pkg::WARM_W'(1);
      end
      b_valid_q <= issue;
      b_emit_q  <= issue_rd;
      // Burst bookkeeping; a new burst may load on the last byte of the old one.
      if (load_burst) begin
        busy_q <= 1'b1;
        left_q <= req_i.count;
      end else if (issue_rd) begin
        left_q <= left_q - lfb_pkg::CNT_W'(1);
        if (left_q == lfb_pkg::CNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  // Chain word and draw pipeline payload.
  always_ff @(posedge clk_i) begin
    if (state_q == lfb_pkg::PH_FILL) begin
      chain_q <= fill_word;
    end
    if (issue) begin
      b_addr_q <= front_q;
      b_last_q <= (left_q == lfb_pkg::CNT_W'(1));
    end
  end

  // Ring write: fill words during seeding, draw sums afterwards.
  assign sum       = rd_front + rd_rear;
  assign ram_we    = !reseed_i && ((state_q == lfb_pkg::PH_FILL) || b_valid_q);
  assign ram_waddr = (state_q == lfb_pkg::PH_FILL) ? fill_idx_q : b_addr_q;
  assign ram_wdata = (state_q == lfb_pkg::PH_FILL) ? fill_word : sum;

  lfb_ram #(
    .WIDTH (lfb_pkg::WORD_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (front_q),
    .raddr_b_i (rear_q),
    .rdata_a_o (rd_front),
    .rdata_b_o (rd_rear)
  );

  // Result queue.
  assign oq_push       = b_valid_q && b_emit_q;
  assign oq_word.rbyte = sum[lfb_pkg::BYTE_LSB +: lfb_pkg::BYTE_W];
  assign oq_word.last  = b_last_q;
  assign empty_o       = (oq_cnt_q == '0);
  assign oq_pop        = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + lfb_pkg::OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + lfb_pkg::OQ_PTR_W'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + lfb_pkg::OQ_CNT_W'(1);
      end else if (oq_pop && !oq_push) begin
        oq_cnt_q <= oq_cnt_q - lfb_pkg::OQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem[oq_wr_q] <= oq_word;
    end
  end

  assign random_byte_o = oq_mem[oq_rd_q].rbyte;
  assign last_o        = oq_mem[oq_rd_q].last;

endmodule

### rtl/lagged_fibonacci_byte_gen.sv
// Lagged Fibonacci byte generator, top level: register port, front and back.
// A taken item loads the back end; each draw passes the registered ring read into
// the result queue; the ring yields one byte per cycle while that queue has room.
// Reset or a register write starts seeding: a chain fill of degree words, a
// remainder run, then 10*degree + remainder discard draws.
// Items are queued meanwhile (two deep); depends on lfb_pkg, lfb_front, lfb_back.
module lagged_fibonacci_byte_gen #(
  parameter int unsigned RING_DEPTH = 1423,
  parameter int unsigned MAX_BURST  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        push,
  input  logic [lfb_pkg::CNT_W-1:0]   byte_count_i,
  output logic                        full,
  output logic                        empty,
  input  logic                        pop,
  output logic [lfb_pkg::BYTE_W-1:0]  random_byte_o,
  output logic                        last_o
);

  logic [lfb_pkg::WORD_W-1:0] seed_q;
  logic [lfb_pkg::LAG_W-1:0]  lag_q;
  logic                       cfg_wr;
  lfb_pkg::reg_idx_e          reg_idx;
  lfb_pkg::burst_req_t        req;
  logic                       req_pop;

  // Register port: writes complete in the access phase, never wait.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = lfb_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= lfb_pkg::SEED_RESET;
      lag_q  <= lfb_pkg::LAG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lfb_pkg::REG_SEED: seed_q <= pwdata;
        lfb_pkg::REG_LAG:  lag_q  <= pwdata[lfb_pkg::LAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      lfb_pkg::REG_SEED: prdata = seed_q;
      lfb_pkg::REG_LAG:  prdata = {{(32 - lfb_pkg::LAG_W){1'b0}}, lag_q};
      default:           prdata = '0;
    endcase
  end

  lfb_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .byte_count_i (byte_count_i),
    .full_o       (full),
    .req_o        (req),
    .req_pop_i    (req_pop)
  );

  lfb_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .reseed_i      (cfg_wr),
    .seed_i        (seed_q),
    .lag_i         (lag_q),
    .req_i         (req),
    .req_pop_o     (req_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .random_byte_o (random_byte_o),
    .last_o        (last_o)
  );

endmodule

### sim/lagged_fibonacci_byte_gen_checker.sv
// Checker for the lagged Fibonacci byte generator: it watches the register
// port and both queue sides, predicts every byte, and counts mismatches.
// Depends on lfb_pkg for field widths and register indexes.
module lagged_fibonacci_byte_gen_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  input  logic                       push,
  input  logic [lfb_pkg::CNT_W-1:0]  byte_count_i,
  input  logic                       full,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [lfb_pkg::BYTE_W-1:0] random_byte_o,
  input  logic                       last_o,
  output int unsigned                mismatch_count,
  output int unsigned                bytes_owed
);

  localparam int unsigned RING_WORDS  = 1423;
  localparam int unsigned BURST_LIMIT = 64;
  localparam logic [31:0] CHAIN_MUL   = 32'd1103515245;
  localparam logic [31:0] CHAIN_INC   = 32'd12345;

  // Degree and separation of the sixteen lag pairs.
  localparam logic [10:0] PAIR_DEGREE [16] = '{
    11'd401, 11'd433, 11'd487, 11'd673, 11'd641, 11'd809, 11'd857, 11'd967,
    11'd1033, 11'd1063, 11'd1129, 11'd1153, 11'd1223, 11'd1249, 11'd1367, 11'd1423
  };
  localparam logic [10:0] PAIR_SEPARATION [16] = '{
    11'd170, 11'd118, 11'd94, 11'd252, 11'd36, 11'd92, 11'd402, 11'd210,
    11'd498, 11'd208, 11'd208, 11'd268, 11'd588, 11'd237, 11'd134, 11'd228
  };

  typedef struct packed {
    logic [lfb_pkg::BYTE_W-1:0] rbyte;
    logic                       last;
  } byte_exp_t;

  // Shadow of the registers and of the generator ring.
  logic [31:0] seed_reg;
  logic [3:0]  lag_reg;
  logic [31:0] ring_mem [RING_WORDS];
  logic [10:0] tap_front;
  logic [10:0] tap_rear;
  logic [10:0] degree;
  byte_exp_t   byte_q [$];

  function automatic logic [10:0] step_tap(input logic [10:0] idx);
    logic [11:0] nxt;
    nxt = idx + 12'd1;
    return (nxt >= degree) ? 11'd0 : nxt[10:0];
  endfunction

  // One additive draw: the sum replaces the front tap word.
  function automatic logic [7:0] draw_byte();
    logic [31:0] sum;
    sum = ring_mem[tap_front] + ring_mem[tap_rear];
    ring_mem[tap_front] = sum;
    tap_front = step_tap(tap_front);
    tap_rear = step_tap(tap_rear);
    return sum[30:23];
  endfunction

  // Fill the ring from the seed chain, set the taps, then discard the warmup draws.
  function automatic void reseed_ring();
    logic [31:0] chain;
    int unsigned discard;
    degree = PAIR_DEGREE[lag_reg];
    chain = seed_reg;
    ring_mem[0] = chain;
    for (int i = 1; i < degree; i++) begin
      chain = chain * CHAIN_MUL + CHAIN_INC;
      ring_mem[i] = chain;
    end
    tap_front = PAIR_SEPARATION[lag_reg];
    tap_rear = 11'd0;
    discard = 10 * degree + (chain % degree);
    repeat (discard) void'(draw_byte());
  endfunction

  always @(posedge clk_i) begin
    byte_exp_t   want;
    int unsigned n;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      seed_reg = 32'd1;
      lag_reg = 4'd0;
      foreach (ring_mem[i]) ring_mem[i] = 32'd0;
      reseed_ring();
      byte_q.delete();
      mismatch_count <= 0;
      bytes_owed <= 0;
    end else begin
      // Register writes reseed the predictor; reads must return the shadow value.
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (lfb_pkg::reg_idx_e'(paddr[2]))
            lfb_pkg::REG_SEED: seed_reg = pwdata;
            lfb_pkg::REG_LAG:  lag_reg = pwdata[3:0];
            default: ;
          endcase
          reseed_ring();
        end else begin
          case (lfb_pkg::reg_idx_e'(paddr[2]))
            lfb_pkg::REG_SEED: if (prdata !== seed_reg) begin
              $error("prdata (seed_value): expected %h, got %h", seed_reg, prdata);
              errs = errs + 1;
            end
            lfb_pkg::REG_LAG: if (prdata !== {28'd0, lag_reg}) begin
              $error("prdata (lag_type): expected %h, got %h", {28'd0, lag_reg}, prdata);
              errs = errs + 1;
            end
            default: ;
          endcase
        end
      end

      // Compare each popped byte with the oldest expectation.
      if (pop && !empty) begin
        if (byte_q.size() == 0) begin
          $error("unexpected result: random_byte %h last %b", random_byte_o, last_o);
          errs = errs + 1;
        end else begin
          want = byte_q.pop_front();
          if (random_byte_o !== want.rbyte) begin
            $error("random_byte: expected %h, got %h", want.rbyte, random_byte_o);
            errs = errs + 1;
          end
          if (last_o !== want.last) begin
            $error("last: expected %b, got %b", want.last, last_o);
            errs = errs + 1;
          end
        end
      end

      // An accepted request yields its bytes; oversized counts saturate.
      if (push && !full) begin
        n = (byte_count_i > BURST_LIMIT) ? BURST_LIMIT : byte_count_i;
        for (int k = 0; k < n; k++) begin
          want.rbyte = draw_byte();
          want.last = (k == n - 1);
          byte_q.push_back(want);
        end
      end
      mismatch_count <= mismatch_count + errs;
      bytes_owed <= byte_q.size();
    end
  end

endmodule

### sim/lagged_fibonacci_byte_gen_tb.sv
// Top of the byte generator testbench: clock, reset, request and register
// stimulus, receiver stalls and the final verdict.
// Depends on lfb_pkg, the generator RTL and lagged_fibonacci_byte_gen_checker.
module lagged_fibonacci_byte_gen_tb;

  localparam int CLK_PERIOD    = 8;
  localparam int LIMIT_CYCLES  = 4000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 58;

  // Directed requests: extremes, zero counts, oversized counts, bit patterns.
  localparam logic [lfb_pkg::CNT_W-1:0] DIRECTED [16] = '{
    7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd0, 7'd63,
    7'd85, 7'd42, 7'd1, 7'd100, 7'd64, 7'd33, 7'd96, 7'd1
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [2:0]                 paddr = 3'd0;
  logic [31:0]                pwdata = 32'd0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       push = 1'b0;
  logic [lfb_pkg::CNT_W-1:0]  byte_count = '0;
  logic                       full;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [lfb_pkg::BYTE_W-1:0] random_byte;
  logic                       last;
  int unsigned                mismatch_count;
  int unsigned                bytes_owed;
  int unsigned                sender_idle_pct = 0;
  int unsigned                receiver_stall_pct = 0;
  logic                       hold_req = 1'b0;

  lagged_fibonacci_byte_gen DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .byte_count_i  (byte_count),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .random_byte_o (random_byte),
    .last_o        (last)
  );

  lagged_fibonacci_byte_gen_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .byte_count_i   (byte_count),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .random_byte_o  (random_byte),
    .last_o         (last),
    .mismatch_count (mismatch_count),
    .bytes_owed     (bytes_owed)
  );

  // Free-running clock.
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Mostly in-range counts, with some oversized and some zero requests.
  function automatic logic [lfb_pkg::CNT_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 15) return lfb_pkg::CNT_W'($urandom_range(65, 127));
    return lfb_pkg::CNT_W'($urandom_range(1, 64));
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic offer_burst(input logic [lfb_pkg::CNT_W-1:0] cnt);
    push <= 1'b1;
    byte_count <= cnt;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted byte has been popped.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (bytes_owed != 0) @(posedge clk_i);
  endtask

  task automatic apb_transfer(input logic is_write, input lfb_pkg::reg_idx_e idx,
                              input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write a register once the block is quiet, then read it back.
  task automatic program_reg(input lfb_pkg::reg_idx_e idx, input logic [31:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_transfer(1'b1, idx, value);
    apb_transfer(1'b0, idx, 32'd0);
  endtask

  // Stimulus: directed requests at the reset setting, then random phases.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) offer_burst(DIRECTED[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: program_reg(lfb_pkg::REG_LAG, $urandom | 32'h0000_000F);
        1: program_reg(lfb_pkg::REG_SEED, 32'hFFFF_FFFF);
        2: program_reg(lfb_pkg::REG_SEED, 32'h0000_0000);
        3: program_reg(lfb_pkg::REG_LAG, $urandom & 32'hFFFF_FFF0);
        4, 6: program_reg(lfb_pkg::REG_LAG, $urandom);
        default: program_reg(lfb_pkg::REG_SEED, $urandom);
      endcase

      // Idling mix cycles through none, sender only, receiver only and both.
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 61;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 61;
        end
        default: begin
          sender_idle_pct = 35;
          receiver_stall_pct = 35;
        end
      endcase

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == PHASE_ITEMS / 2) drain_results();
        if (ph == 4 && i == 10) hold_req = 1'b1;
        offer_burst(pick_count());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
